// ----- hdl/qtre_pkg.sv -----
// Shared types and constants for the quantized temperature ramp estimator.
package qtre_pkg;

  localparam int TEMP_W       = 8;
  localparam int EST_W        = 18;
  localparam int CFG_W        = 11;
  localparam int CFG_IDX_W    = 1;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;

  localparam logic [CFG_W-1:0] RAMP_BAND_RST   = 11'd256;
  localparam logic [CFG_W-1:0] HOLD_OFFSET_RST = 11'd282;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAMP_BAND   = 1'b0,
    REG_HOLD_OFFSET = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] ramp_band;
    logic [CFG_W-1:0] hold_offset;
  } chan_cfg_t;

endpackage

// ----- hdl/qtre_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module qtre_div import qtre_pkg::*; #(
  parameter int DIVD_W = 16,
  parameter int DIVS_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quot
);

  localparam int CNT_W = $clog2(DIVD_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVS_W-1:0] dvs_r, dvs_nxt;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    trial    = {rem_r, quo_r[DIVD_W-1]};
    diff     = trial - {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      // a zero interval divides as one
      dvs_nxt  = (divisor == '0) ? DIVS_W'(1) : divisor;
    end else if (busy_r) begin
      if (!diff[DIVS_W]) begin
        rem_nxt = diff[DIVS_W-1:0];
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIVS_W-1:0];
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIVD_W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ----- hdl/qtre_chan.sv -----
// Per-channel state and estimate update.
module qtre_chan import qtre_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          commit,
  input  logic [TEMP_W-1:0]             reading,
  input  logic [TEMP_W+FRAC_BITS-1:0]   inc,
  input  chan_cfg_t                     cfg,
  output logic [TEMP_W-1:0]             step,
  output logic [COUNT_WIDTH-1:0]        interval,
  output logic signed [EST_W-1:0]       estimate
);

  localparam int INC_W = TEMP_W + FRAC_BITS;
  // wide enough for base + band, estimate + increment, with sign
  localparam int IW = ((INC_W > EST_W) ? INC_W : EST_W) + 3;

  logic [TEMP_W-1:0]       prior_r, prior_nxt;
  logic [TEMP_W-1:0]       step_r, step_nxt;
  logic [COUNT_WIDTH-1:0]  intv_r, intv_nxt;
  logic [COUNT_WIDTH-1:0]  ticks_r, ticks_nxt;
  logic                    rising_r, rising_nxt;
  logic signed [EST_W-1:0] est_r, est_nxt;

  logic signed [IW-1:0] base_s;
  logic signed [IW-1:0] cur_s;
  logic signed [IW-1:0] band_s;
  logic signed [IW-1:0] hold_s;
  logic signed [IW-1:0] inc_s;
  logic signed [IW-1:0] raw_s;
  logic                 up;

  always_comb begin
    base_s     = signed'({{(IW-INC_W){1'b0}}, reading, {FRAC_BITS{1'b0}}});
    cur_s      = IW'(est_r);
    band_s     = signed'({{(IW-CFG_W){1'b0}}, cfg.ramp_band});
    hold_s     = signed'({{(IW-CFG_W){1'b0}}, cfg.hold_offset});
    inc_s      = signed'({{(IW-INC_W){1'b0}}, inc});
    up         = reading > prior_r;
    prior_nxt  = reading;
    step_nxt   = step_r;
    intv_nxt   = intv_r;
    ticks_nxt  = ticks_r;
    rising_nxt = rising_r;
    raw_s      = cur_s;
    if (reading != prior_r) begin
      step_nxt   = up ? (reading - prior_r) : (prior_r - reading);
      intv_nxt   = ticks_r;
      ticks_nxt  = '0;
      rising_nxt = up;
      raw_s      = base_s;
    end else begin
      if (ticks_r != '1) ticks_nxt = ticks_r + COUNT_WIDTH'(1);
      if (rising_r) begin
        raw_s = (cur_s < base_s + band_s) ? cur_s + inc_s : base_s + hold_s;
      end else begin
        raw_s = (cur_s > base_s - band_s) ? cur_s - inc_s : base_s - hold_s;
      end
    end
    // saturate to the 18 bit range
    if (raw_s[IW-1:EST_W-1] == '0 || raw_s[IW-1:EST_W-1] == '1) begin
      est_nxt = raw_s[EST_W-1:0];
    end else if (raw_s[IW-1]) begin
      est_nxt = {1'b1, {(EST_W-1){1'b0}}};
    end else begin
      est_nxt = {1'b0, {(EST_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_r  <= '0;
      step_r   <= '0;
      intv_r   <= '0;
      ticks_r  <= '0;
      rising_r <= 1'b0;
      est_r    <= '0;
    end else if (commit) begin
      prior_r  <= prior_nxt;
      step_r   <= step_nxt;
      intv_r   <= intv_nxt;
      ticks_r  <= ticks_nxt;
      rising_r <= rising_nxt;
      est_r    <= est_nxt;
    end
  end

  assign step     = step_r;
  assign interval = intv_r;
  assign estimate = est_nxt;

endmodule

// ----- hdl/quantized_temp_ramp_estimator_top.sv -----
// Top level of the two-channel quantized temperature ramp estimator.
//
// Usage: each input item carries two whole-degree readings (in_temp_a,
// in_temp_b); each one yields exactly one result item with two smoothed
// estimates in 1/2^FRAC_BITS degree, 18 bit two's complement.
// Channels use valid/stall; an item moves on an edge with valid high and
// stall low. in_stall is high while an item is being worked on.
// Timing: one shared serial divider forms step/interval for channel A,
// then channel B, one quotient bit per cycle. The next item is accepted
// only once the state has gone from ST_DIV_A through ST_DIV_B and
// ST_COMMIT back to ST_IDLE; the result is registered at commit.
// The result sits in an output register, so a new item can be accepted
// while the previous result is still stalled; the next result then waits
// (and state is not updated) until the register is taken.
// Reset (rst_n low, synchronous) clears all channel state, returns
// ramp_band to 256 and hold_offset to 282 and empties the output.
// Configuration: cfg_we with cfg_index/cfg_data, write only while idle.
module quantized_temp_ramp_estimator_top import qtre_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [TEMP_W-1:0]       in_temp_a,
  input  logic [TEMP_W-1:0]       in_temp_b,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [EST_W-1:0] out_estimate_a,
  output logic signed [EST_W-1:0] out_estimate_b
);

  localparam int DIVD_W = TEMP_W + FRAC_BITS;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DIV_A  = 4'b0010,
    ST_DIV_B  = 4'b0100,
    ST_COMMIT = 4'b1000
  } seq_state_t;

  seq_state_t state_r, state_nxt;

  chan_cfg_t cfg_r;

  logic [TEMP_W-1:0]       temp_a_r, temp_b_r;
  logic [DIVD_W-1:0]       inc_a_r;
  logic                    out_valid_r;
  logic signed [EST_W-1:0] est_a_out_r, est_b_out_r;

  logic                    accept;
  logic                    commit;
  logic                    div_start;
  logic                    div_done;
  logic [DIVD_W-1:0]       div_quot;
  logic [DIVD_W-1:0]       div_dividend;
  logic [COUNT_WIDTH-1:0]  div_divisor;

  logic [TEMP_W-1:0]       step_a, step_b;
  logic [COUNT_WIDTH-1:0]  intv_a, intv_b;
  logic signed [EST_W-1:0] est_a, est_b;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  // state moves forward only once the output register can take the item
  assign commit   = (state_r == ST_COMMIT) && (!out_valid_r || !out_stall);

  assign div_start = accept || ((state_r == ST_DIV_A) && div_done);

  // operands: channel A at acceptance, channel B after
  always_comb begin
    if (state_r == ST_IDLE) begin
      div_dividend = {step_a, {FRAC_BITS{1'b0}}};
      div_divisor  = intv_a;
    end else begin
      div_dividend = {step_b, {FRAC_BITS{1'b0}}};
      div_divisor  = intv_b;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_DIV_A;
      ST_DIV_A:  if (div_done) state_nxt = ST_DIV_B;
      ST_DIV_B:  if (div_done) state_nxt = ST_COMMIT;
      ST_COMMIT: if (commit) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      out_valid_r       <= 1'b0;
      cfg_r.ramp_band   <= RAMP_BAND_RST;
      cfg_r.hold_offset <= HOLD_OFFSET_RST;
    end else begin
      state_r <= state_nxt;
      if (commit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_RAMP_BAND:   cfg_r.ramp_band   <= cfg_data;
          REG_HOLD_OFFSET: cfg_r.hold_offset <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      temp_a_r <= in_temp_a;
      temp_b_r <= in_temp_b;
    end
    if ((state_r == ST_DIV_A) && div_done) inc_a_r <= div_quot;
    if (commit) begin
      est_a_out_r <= est_a;
      est_b_out_r <= est_b;
    end
  end

  qtre_div #(
    .DIVD_W (DIVD_W),
    .DIVS_W (COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  qtre_chan #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_chan_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .commit   (commit),
    .reading  (temp_a_r),
    .inc      (inc_a_r),
    .cfg      (cfg_r),
    .step     (step_a),
    .interval (intv_a),
    .estimate (est_a)
  );

  // channel B's quotient stays in the divider until the next start
  qtre_chan #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_chan_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .commit   (commit),
    .reading  (temp_b_r),
    .inc      (div_quot),
    .cfg      (cfg_r),
    .step     (step_b),
    .interval (intv_b),
    .estimate (est_b)
  );

  assign out_valid      = out_valid_r;
  assign out_estimate_a = est_a_out_r;
  assign out_estimate_b = est_b_out_r;

endmodule

// ----- hdl/qtre_chk.sv -----
// Port-level checker for the estimator top level, with its bind.
module qtre_chk import qtre_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [EST_W-1:0] out_estimate_a,
  input logic signed [EST_W-1:0] out_estimate_b
);

  // a new item keeps the input side busy on the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again straight after an item");

  // results never appear in the cycle after acceptance
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result appeared too early");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_estimate_a) && $stable(out_estimate_b)))
    else $error("stalled result changed");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind quantized_temp_ramp_estimator_top qtre_chk u_qtre_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_estimate_a (out_estimate_a),
  .out_estimate_b (out_estimate_b)
);

// ----- bench/tb_quantized_temp_ramp_estimator_top.sv -----
// Self-checking testbench for the two-channel quantized temperature ramp estimator.
module tb_quantized_temp_ramp_estimator_top;
  import qtre_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC       = FRAC_BITS_DEF;
  localparam int EST_MAX    = 131071;
  localparam int EST_MIN    = -131072;
  localparam int ITEMS_RUN  = 280;     // random items per configuration phase
  localparam int SETTLE     = 40;      // a little over one item's latency
  localparam int HOLD_LEN   = 400;     // long receiver hold-off
  localparam int STUCK_MAX  = 4000;    // cycles with no item moving before giving up

  typedef struct packed {
    logic [TEMP_W-1:0] a;
    logic [TEMP_W-1:0] b;
  } temp_pair_t;

  typedef struct packed {
    logic [EST_W-1:0] a;
    logic [EST_W-1:0] b;
  } est_pair_t;

  // DUT connections, inputs all known from time zero
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [TEMP_W-1:0]       in_temp_a = '0;
  logic [TEMP_W-1:0]       in_temp_b = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [EST_W-1:0] out_estimate_a;
  logic signed [EST_W-1:0] out_estimate_b;

  quantized_temp_ramp_estimator_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_temp_a      (in_temp_a),
    .in_temp_b      (in_temp_b),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_estimate_a (out_estimate_a),
    .out_estimate_b (out_estimate_b)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Estimator model: own copy of the per-channel state and the two registers
  // ---------------------------------------------------------------------------
  chan_cfg_t                model_cfg;
  logic [TEMP_W-1:0]        last_temp   [2];
  logic [7:0]               step_mag    [2];
  logic [15:0]              lvl_ticks   [2];   // length of the previous level
  logic [COUNT_WIDTH_DEF-1:0] dwell_ticks [2]; // ticks at the current level, saturating
  logic                     rising      [2];
  logic signed [EST_W-1:0]  smooth_est  [2];

  est_pair_t  queued_estimates [$];   // results owed by the block, oldest first
  temp_pair_t pending_temps    [$];   // items still to be offered

  int fail_count = 0;

  // Advance one channel by one reading and return its new estimate.
  function automatic logic [EST_W-1:0] advance_estimate(input int ch,
                                                         input logic [TEMP_W-1:0] reading);
    longint base;
    longint est;
    longint div;
    longint inc;
    logic   up;
    base = longint'(reading) << FRAC;
    est  = longint'(smooth_est[ch]);
    if (reading != last_temp[ch]) begin
      // new level: jump to the reading, remember step, direction and old dwell
      up = (reading > last_temp[ch]);
      step_mag[ch]    = up ? reading - last_temp[ch] : last_temp[ch] - reading;
      lvl_ticks[ch]   = dwell_ticks[ch];
      dwell_ticks[ch] = '0;
      rising[ch]      = up;
      est = base;
    end else begin
      // same level: ramp by step/interval, a zero interval counts as one
      div = (lvl_ticks[ch] == '0) ? 1 : longint'(lvl_ticks[ch]);
      inc = (longint'(step_mag[ch]) << FRAC) / div;
      if (dwell_ticks[ch] != '1)
        dwell_ticks[ch] = dwell_ticks[ch] + 1'b1;
      if (rising[ch]) begin
        if (est < base + longint'(model_cfg.ramp_band)) est = est + inc;
        else est = base + longint'(model_cfg.hold_offset);
      end else begin
        if (est > base - longint'(model_cfg.ramp_band)) est = est - inc;
        else est = base - longint'(model_cfg.hold_offset);
      end
    end
    if (est > EST_MAX) est = EST_MAX;
    if (est < EST_MIN) est = EST_MIN;
    smooth_est[ch] = est[EST_W-1:0];
    last_temp[ch]  = reading;
    return smooth_est[ch];
  endfunction

  initial begin
    model_cfg.ramp_band   = RAMP_BAND_RST;
    model_cfg.hold_offset = HOLD_OFFSET_RST;
    for (int ch = 0; ch < 2; ch++) begin
      last_temp[ch]   = '0;
      step_mag[ch]    = '0;
      lvl_ticks[ch]   = '0;
      dwell_ticks[ch] = '0;
      rising[ch]      = 1'b0;
      smooth_est[ch]  = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: the model runs on every item the block accepts
  // ---------------------------------------------------------------------------
  logic item_taken = 1'b0;

  always @(posedge clk) begin : accept_blk
    est_pair_t due;
    item_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      due.a = advance_estimate(0, in_temp_a);
      due.b = advance_estimate(1, in_temp_b);
      queued_estimates.push_back(due);
    end
  end

  int send_idle_pct = 37;
  int recv_idle_pct = 49;

  // Driver: offers the next item at the falling edge once the last one has gone.
  // A stalled item stays put; between items the payload carries junk.
  always @(negedge clk) begin : drive_blk
    temp_pair_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_taken) begin
      if (pending_temps.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_temps.pop_front();
        in_valid  <= 1'b1;
        in_temp_a <= nxt.a;
        in_temp_b <= nxt.b;
      end else begin
        in_valid  <= 1'b0;
        in_temp_a <= TEMP_W'($urandom);
        in_temp_b <= TEMP_W'($urandom);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random stalls plus a long hold-off on request
  // ---------------------------------------------------------------------------
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: every result taken is checked against the oldest owed estimate pair.
  always @(posedge clk) begin : check_blk
    est_pair_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (queued_estimates.size() == 0) begin
        $display("%0t ns: result with nothing owed, got a=%0d b=%0d",
                 $time, out_estimate_a, out_estimate_b);
        fail_count++;
      end else begin
        due = queued_estimates.pop_front();
        if (out_estimate_a !== due.a) begin
          $display("%0t ns: estimate_a mismatch, expected %0d, got %0d",
                   $time, $signed(due.a), out_estimate_a);
          fail_count++;
        end
        if (out_estimate_b !== due.b) begin
          $display("%0t ns: estimate_b mismatch, expected %0d, got %0d",
                   $time, $signed(due.b), out_estimate_b);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: cycles in which no item moves on either side
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    while (stuck_cycles < STUCK_MAX) @(posedge clk);
    $display("%0t ns: no progress, %0d results still owed", $time, queued_estimates.size());
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic [TEMP_W-1:0] gen_level [2] = '{8'd0, 8'd0};
  int                gen_dwell [2] = '{0, 0};

  // Readings that hold a level for a while and then step, mostly by a little.
  function automatic logic [TEMP_W-1:0] next_reading(input int ch);
    int r;
    int delta;
    int lvl;
    if (gen_dwell[ch] == 0) begin
      r = $urandom_range(99);
      if (r < 60) begin
        delta = $urandom_range(4, 1);
        lvl = int'(gen_level[ch]) + ($urandom_range(1) ? delta : -delta);
        if (lvl > 255 || lvl < 0) lvl = int'(gen_level[ch]) - (lvl - int'(gen_level[ch]));
        gen_level[ch] = lvl[TEMP_W-1:0];
      end else if (r < 85) begin
        gen_level[ch] = TEMP_W'($urandom);
      end else begin
        gen_level[ch] = $urandom_range(1) ? 8'd255 : 8'd0;
      end
      r = $urandom_range(99);
      if (r < 60) gen_dwell[ch] = $urandom_range(6);
      else if (r < 92) gen_dwell[ch] = $urandom_range(40, 7);
      else gen_dwell[ch] = $urandom_range(200, 41);
    end else begin
      gen_dwell[ch]--;
    end
    return gen_level[ch];
  endfunction

  task automatic queue_temps(input int a, input int b, input int reps);
    temp_pair_t p;
    p.a = a[TEMP_W-1:0];
    p.b = b[TEMP_W-1:0];
    repeat (reps) pending_temps.push_back(p);
  endtask

  task automatic queue_random(input int n);
    temp_pair_t p;
    repeat (n) begin
      if ($urandom_range(99) < 8) begin
        // noise: unrelated readings that break the level sequences
        p.a = TEMP_W'($urandom);
        p.b = TEMP_W'($urandom);
      end else begin
        p.a = next_reading(0);
        p.b = next_reading(1);
      end
      pending_temps.push_back(p);
    end
  endtask

  // Wait until every item has gone in and every owed result has come out.
  task automatic drain();
    @(posedge clk);
    while (pending_temps.size() != 0 || in_valid || queued_estimates.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_RAMP_BAND:   model_cfg.ramp_band   = val;
      REG_HOLD_OFFSET: model_cfg.hold_offset = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // band / hold pairs for each phase; the last phase picks its own
  int band_set [6] = '{256, 0, 1024, 0, 1024, 0};
  int hold_set [6] = '{282, 0, 1024, 1024, 0, 0};

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset settings
    queue_temps(0, 0, 3);        // unchanged reading straight after reset
    queue_temps(255, 0, 4);      // full rising step after three quiet ticks, then hold
    queue_temps(254, 1, 1);      // falling step of one against rising step of one
    queue_temps(0, 255, 4);      // back-to-back change: zero interval, big ramp
    queue_temps(128, 128, 1);
    queue_temps(129, 127, 6);    // single-degree steps ramping into the hold band
    queue_temps(255, 0, 1);
    queue_temps(0, 255, 4);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        repeat (SETTLE) @(posedge clk);
        if (ph == 5) begin
          band_set[ph] = $urandom_range(1024);
          hold_set[ph] = $urandom_range(1024);
        end
        write_cfg(REG_RAMP_BAND, band_set[ph][CFG_W-1:0]);
        write_cfg(REG_HOLD_OFFSET, hold_set[ph][CFG_W-1:0]);
        @(posedge clk);
      end

      // receiver-heavy idling first, then sender-heavy, then none
      if (ph < 2) begin
        send_idle_pct = 37;
        recv_idle_pct = 49;
      end else if (ph < 4) begin
        send_idle_pct = 49;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (ph == 3) begin
        // sender goes quiet mid-phase until the block has emptied
        queue_random(ITEMS_RUN / 2);
        drain();
        queue_random(ITEMS_RUN - ITEMS_RUN / 2);
      end else begin
        queue_random(ITEMS_RUN);
      end

      // receiver sits on its input while items keep coming, so the block backs up
      if (ph == 1) hold_req = hold_req + 1;
    end

    drain();
    repeat (SETTLE) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
